FILE: hw/rtl/otaa_pkg.sv
`timescale 1ns / 1ps

package otaa_pkg;

  // Payload widths of the streaming channels
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Join watchdog and retry wait after a watchdog expiry, in milliseconds
  localparam logic [31:0] JOIN_TIMEOUT = 32'd20000;
  localparam logic [31:0] RETRY_DELAY  = 32'd5000;

  // Fixed waits of the sequence, in milliseconds
  localparam logic [31:0] SHORT_WAIT   = 32'd300;
  localparam logic [31:0] LONG_WAIT    = 32'd500;
  localparam logic [31:0] JOINED_WAIT  = 32'd10000;
  localparam logic [31:0] FAIL_WAIT    = 32'd5000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPLINK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ID        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_APP_ID        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY           = 3'd4;

  // Sequence steps
  localparam logic [3:0] STEP_PING    = 4'd0;
  localparam logic [3:0] STEP_VERSION = 4'd1;
  localparam logic [3:0] STEP_MODE    = 4'd2;
  localparam logic [3:0] STEP_REGION  = 4'd3;
  localparam logic [3:0] STEP_DEVID   = 4'd4;
  localparam logic [3:0] STEP_APPID   = 4'd5;
  localparam logic [3:0] STEP_KEY     = 4'd6;
  localparam logic [3:0] STEP_JOIN    = 4'd7;
  localparam logic [3:0] STEP_JOINED  = 4'd8;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_PING    = 4'd1,
    CMD_VERSION = 4'd2,
    CMD_MODE    = 4'd3,
    CMD_REGION  = 4'd4,
    CMD_DEVID   = 4'd5,
    CMD_APPID   = 4'd6,
    CMD_KEY     = 4'd7,
    CMD_JOIN    = 4'd8,
    CMD_UPLINK  = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [30:0] uplink_period;
    logic [30:0] startup_delay;
    logic        dev_id_present;
    logic        app_id_present;
    logic        key_present;
  } cfg_t;

  typedef struct packed {
    logic        running;
    logic [3:0]  step_index;
    logic [31:0] next_action_time;
    logic [31:0] join_deadline;
    logic [31:0] last_uplink_time;
    logic        joined_flag;
  } seq_state_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_time;
    logic        join_ok;
    logic        join_fail;
    logic        link_accepts;
  } seq_in_t;

  typedef struct packed {
    cmd_t       command;
    logic       is_joined;
    logic [3:0] phase;
  } seq_out_t;

  // Step that follows the region step or one of the optional identity steps.
  function automatic logic [3:0] after_region(input logic [3:0] from, input cfg_t c);
    logic [3:0] nxt;
    if (from < STEP_DEVID && c.dev_id_present) begin
      nxt = STEP_DEVID;
    end else if (from < STEP_APPID && c.app_id_present) begin
      nxt = STEP_APPID;
    end else if (from < STEP_KEY && c.key_present) begin
      nxt = STEP_KEY;
    end else begin
      nxt = STEP_JOIN;
    end
    return nxt;
  endfunction

  // A deadline is reached when (now - deadline) mod 2^32 is below 2^31.
  function automatic logic reached(input logic [31:0] now, input logic [31:0] due);
    logic [31:0] diff;
    diff = now - due;
    return ~diff[31];
  endfunction

endpackage

FILE: hw/rtl/otaa_cfg.sv
`timescale 1ns / 1ps

module otaa_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [otaa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [otaa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output otaa_pkg::cfg_t                     cfg_o
);

  otaa_pkg::cfg_t cfg_r;
  otaa_pkg::cfg_t cfg_nxt;

  // Registers are plain flops, so a write is taken in every cycle.
  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        otaa_pkg::REG_UPLINK_PERIOD: cfg_nxt.uplink_period  = cfg_data;
        otaa_pkg::REG_STARTUP_DELAY: cfg_nxt.startup_delay  = cfg_data;
        otaa_pkg::REG_DEV_ID:        cfg_nxt.dev_id_present = cfg_data[0];
        otaa_pkg::REG_APP_ID:        cfg_nxt.app_id_present = cfg_data[0];
        otaa_pkg::REG_KEY:           cfg_nxt.key_present    = cfg_data[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.uplink_period  <= 31'd60000;
      cfg_r.startup_delay  <= '0;
      cfg_r.dev_id_present <= 1'b0;
      cfg_r.app_id_present <= 1'b0;
      cfg_r.key_present    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/otaa_step.sv
`timescale 1ns / 1ps

module otaa_step (
  input  otaa_pkg::cfg_t       cfg_i,
  input  otaa_pkg::seq_state_t st_i,
  input  otaa_pkg::seq_in_t    item_i,
  output otaa_pkg::seq_state_t st_o,
  output otaa_pkg::seq_out_t   res_o
);

  // A wait that was just restarted from now is due only if the wait is zero.
  localparam logic RETRY_DUE = (otaa_pkg::RETRY_DELAY == 32'd0);
  localparam logic FAIL_DUE  = (otaa_pkg::FAIL_WAIT == 32'd0);

  logic [31:0] now;
  logic [31:0] t_start, t_short, t_long, t_joined, t_watch, t_retry, t_fail;
  logic [31:0] since_uplink;
  logic        act_due, wd_fire, uplink_due, due;
  logic [3:0]  s;
  otaa_pkg::cmd_t cmd;

  assign now          = item_i.now_time;
  assign t_start      = now + {1'b0, cfg_i.startup_delay};
  assign t_short      = now + otaa_pkg::SHORT_WAIT;
  assign t_long       = now + otaa_pkg::LONG_WAIT;
  assign t_joined     = now + otaa_pkg::JOINED_WAIT;
  assign t_watch      = now + otaa_pkg::JOIN_TIMEOUT;
  assign t_retry      = now + otaa_pkg::RETRY_DELAY;
  assign t_fail       = now + otaa_pkg::FAIL_WAIT;
  assign since_uplink = now - st_i.last_uplink_time;
  assign act_due      = otaa_pkg::reached(now, st_i.next_action_time);
  assign uplink_due   = since_uplink >= {1'b0, cfg_i.uplink_period};
  assign wd_fire      = (st_i.step_index == otaa_pkg::STEP_JOINED) && !st_i.joined_flag &&
                        (st_i.join_deadline != 32'd0) &&
                        otaa_pkg::reached(now, st_i.join_deadline);

  always_comb begin
    st_o = st_i;
    cmd  = otaa_pkg::CMD_NONE;
    due  = act_due;
    s    = st_i.step_index;
    if (item_i.mode) begin
      st_o.running          = 1'b1;
      st_o.next_action_time = t_start;
      st_o.last_uplink_time = '0;
      st_o.step_index       = otaa_pkg::STEP_PING;
      st_o.joined_flag      = 1'b0;
    end else if (st_i.running) begin
      if (wd_fire) begin
        st_o.join_deadline    = '0;
        st_o.step_index       = otaa_pkg::STEP_JOIN;
        st_o.next_action_time = t_retry;
        due                   = RETRY_DUE;
      end
      if (item_i.join_fail && !item_i.join_ok) begin
        st_o.joined_flag      = 1'b0;
        st_o.join_deadline    = '0;
        st_o.step_index       = otaa_pkg::STEP_JOIN;
        st_o.next_action_time = t_fail;
        due                   = FAIL_DUE;
      end
      if (item_i.join_ok) begin
        st_o.joined_flag   = 1'b1;
        st_o.join_deadline = '0;
        st_o.step_index    = otaa_pkg::STEP_JOINED;
      end
      s = st_o.step_index;
      if (due && s <= otaa_pkg::STEP_JOIN) begin
        cmd = otaa_pkg::cmd_t'(s + 4'd1);
        if (item_i.link_accepts) begin
          if (s <= otaa_pkg::STEP_MODE) begin
            st_o.step_index       = s + 4'd1;
            st_o.next_action_time = t_short;
          end else if (s <= otaa_pkg::STEP_KEY) begin
            st_o.step_index       = otaa_pkg::after_region(s, cfg_i);
            st_o.next_action_time = t_long;
          end else begin
            st_o.step_index       = otaa_pkg::STEP_JOINED;
            st_o.next_action_time = t_joined;
            st_o.join_deadline    = t_watch;
          end
        end
      end
      if (st_o.joined_flag && cmd == otaa_pkg::CMD_NONE && uplink_due) begin
        cmd = otaa_pkg::CMD_UPLINK;
        if (item_i.link_accepts) begin
          st_o.last_uplink_time = now;
        end
      end
    end
  end

  assign res_o.command   = cmd;
  assign res_o.is_joined = st_o.joined_flag;
  assign res_o.phase     = st_o.step_index;

endmodule

FILE: hw/rtl/otaa_join_sequencer_unit.sv
`timescale 1ns / 1ps
// Pipeline: a transaction accepted on the input is held in the input register, then moves
// on into the result register, from which the output side takes it; a stalled output
// backs up into the input register.
// Throughput: one transaction per cycle, limited only by the output side's tready.
// Reset: synchronous, active low; clears the sequencer state, both pipeline stages and
// returns the configuration registers to their documented reset values.

module otaa_join_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] now_time, [32] join_ok, [33] join_fail, [34] link_accepts, [39:35] zero
  input  logic [otaa_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] mode: 0 tick, 1 start managed join
  input  logic                               in_tuser,

  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] command, [4] is_joined, [8:5] phase, [15:9] zero
  output logic [otaa_pkg::OUT_DATA_W-1:0]    out_tdata,

  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [otaa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [otaa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  otaa_pkg::cfg_t       cfg;
  otaa_pkg::seq_state_t st_r, st_nxt;
  otaa_pkg::seq_in_t    item_r, item_nxt;
  otaa_pkg::seq_out_t   res, res_r;
  logic                 item_valid_r, item_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_take, advance;

  otaa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // The input register holds one transaction. It moves on into the result register
  // whenever that register is empty or being drained this cycle, so a stalled output
  // only backs up into the input stage and the state is updated exactly once per item.
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    item_nxt.mode         = in_tuser;
    item_nxt.now_time     = in_tdata[31:0];
    item_nxt.join_ok      = in_tdata[32];
    item_nxt.join_fail    = in_tdata[33];
    item_nxt.link_accepts = in_tdata[34];
  end

  always_comb begin
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // All sequencing decisions for one tick are made here, against the state left by the
  // previous tick. The new state is committed in the same cycle the result is captured.
  otaa_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_r),
    .item_i (item_r),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.phase, res_r.is_joined, res_r.command};

endmodule

FILE: hw/rtl/otaa_checker.sv
`timescale 1ns / 1ps

module otaa_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [otaa_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Joined is only ever reported together with the joined step.
  a_joined_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[8:5] == otaa_pkg::STEP_JOINED)
    else $error("joined reported outside the joined step");

  // Uplinks are requested only once joined.
  a_uplink_joined: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == otaa_pkg::CMD_UPLINK |-> out_tdata[4])
    else $error("uplink requested while not joined");

  // A step command leaves the sequence at that step or beyond it.
  a_cmd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != otaa_pkg::CMD_NONE &&
    out_tdata[3:0] != otaa_pkg::CMD_UPLINK |-> out_tdata[8:5] + 4'd1 >= out_tdata[3:0])
    else $error("step command does not match the reported phase");

  // Command and phase codes stay within their defined ranges.
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= otaa_pkg::CMD_UPLINK &&
                   out_tdata[8:5] <= otaa_pkg::STEP_JOINED)
    else $error("result code out of range");

endmodule

bind otaa_join_sequencer_unit otaa_checker u_otaa_checker (.*);
